@@ design/hcbd_pkg.sv @@
// Shared types, character codes and helpers for the chunked body decoder.
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TotalW = 32;

  // Framing and white space characters
  localparam logic [ByteW-1:0] ChrCr  = 8'h0D;
  localparam logic [ByteW-1:0] ChrLf  = 8'h0A;
  localparam logic [ByteW-1:0] ChrSp  = 8'h20;
  localparam logic [ByteW-1:0] ChrTab = 8'h09;
  localparam logic [ByteW-1:0] ChrVt  = 8'h0B;
  localparam logic [ByteW-1:0] ChrFf  = 8'h0C;

  // Decoder phases
  typedef enum logic [1:0] {
    PhSize = 2'd0,
    PhData = 2'd1,
    PhTail = 2'd2,
    PhDone = 2'd3
  } hcbd_phase_e;

  // One input word
  typedef struct packed {
    logic [ByteW-1:0] body_byte;
    logic             restart;
  } hcbd_in_t;

  // One result word
  typedef struct packed {
    logic              payload_valid;
    logic [ByteW-1:0]  payload_byte;
    logic              chunk_end;
    logic              body_done;
    logic              size_overflow;
    logic [TotalW-1:0] total_payload;
  } hcbd_out_t;

  // Decoded hex character
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hcbd_hex_t;

  function automatic hcbd_hex_t hex_decode(input logic [ByteW-1:0] c);
    hcbd_hex_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [ByteW-1:0] c);
    return (c == ChrSp) || (c == ChrTab) || (c == ChrVt) || (c == ChrFf);
  endfunction

endpackage

@@ design/hcbd_frame.sv @@
// Framing state and per-byte phase update of the chunked body decoder.
`timescale 1ns / 1ps

module hcbd_frame import hcbd_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 31,
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  hcbd_in_t  item_i,
  output hcbd_out_t res_o
);

  localparam int unsigned CharW = $clog2(MAX_DIGITS + 1);
  localparam logic [CharW-1:0] MaxChars = CharW'(MAX_DIGITS);

  hcbd_phase_e             phase_q, phase_d, cur_phase;
  logic [SIZE_WIDTH-1:0]   accum_q, accum_d, cur_accum;
  logic [SIZE_WIDTH-1:0]   remain_q, remain_d, cur_remain;
  logic [CharW-1:0]        chars_q, chars_d, cur_chars;
  logic                    stop_q, stop_d, cur_stop;
  logic                    seen_q, seen_d, cur_seen;
  logic                    ovf_q, ovf_d, cur_ovf;
  logic [TotalW-1:0]       total_q, total_d, cur_total;

  logic      is_cr, is_lf, last_byte;
  hcbd_hex_t hex;

  // Restart drops the state back to reset before this byte
  always_comb begin
    if (item_i.restart) begin
      cur_phase  = PhSize;
      cur_accum  = '0;
      cur_remain = '0;
      cur_chars  = '0;
      cur_stop   = 1'b0;
      cur_seen   = 1'b0;
      cur_ovf    = 1'b0;
      cur_total  = '0;
    end else begin
      cur_phase  = phase_q;
      cur_accum  = accum_q;
      cur_remain = remain_q;
      cur_chars  = chars_q;
      cur_stop   = stop_q;
      cur_seen   = seen_q;
      cur_ovf    = ovf_q;
      cur_total  = total_q;
    end
  end

  assign is_cr     = (item_i.body_byte == ChrCr);
  assign is_lf     = (item_i.body_byte == ChrLf);
  assign hex       = hex_decode(item_i.body_byte);
  assign last_byte = (cur_remain == SIZE_WIDTH'(1));

  // Next phase
  always_comb begin
    phase_d = cur_phase;
    case (cur_phase)
      PhSize: begin
        if (is_lf) begin
          phase_d = (cur_accum == '0) ? PhDone : PhData;
        end
      end
      PhData: begin
        if (last_byte) begin
          phase_d = PhTail;
        end
      end
      PhTail: begin
        if (is_lf) begin
          phase_d = PhSize;
        end
      end
      PhDone: begin
        phase_d = PhDone;
      end
      default: begin
        phase_d = cur_phase;
      end
    endcase
  end

  // Size line parsing and payload counting
  always_comb begin
    accum_d  = cur_accum;
    remain_d = cur_remain;
    chars_d  = cur_chars;
    stop_d   = cur_stop;
    seen_d   = cur_seen;
    ovf_d    = cur_ovf;
    total_d  = cur_total;
    case (cur_phase)
      PhSize: begin
        if (is_lf) begin
          remain_d = cur_accum;
          accum_d  = '0;
          chars_d  = '0;
          stop_d   = 1'b0;
          seen_d   = 1'b0;
        end else if (!is_cr && (cur_chars < MaxChars)) begin
          chars_d = cur_chars + CharW'(1);
          if (!cur_stop) begin
            if (hex.ok) begin
              seen_d = 1'b1;
              // saturate when another digit would not fit
              if (cur_accum[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                accum_d = '1;
                ovf_d   = 1'b1;
              end else begin
                accum_d = {cur_accum[SIZE_WIDTH-5:0], hex.val};
              end
            end else if (cur_seen || !is_blank(item_i.body_byte)) begin
              stop_d = 1'b1;
            end
          end
        end
      end
      PhData: begin
        remain_d = cur_remain - SIZE_WIDTH'(1);
        if (cur_total != '1) begin
          total_d = cur_total + TotalW'(1);
        end
      end
      default: begin
        remain_d = cur_remain;
      end
    endcase
  end

  // Result word
  always_comb begin
    res_o.payload_valid = (cur_phase == PhData);
    res_o.payload_byte  = (cur_phase == PhData) ? item_i.body_byte : '0;
    res_o.chunk_end     = (cur_phase == PhData) && last_byte;
    res_o.body_done     = (phase_d == PhDone);
    res_o.size_overflow = ovf_d;
    res_o.total_payload = total_d;
  end

  // Commit state when a word passes through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSize;
      accum_q  <= '0;
      remain_q <= '0;
      chars_q  <= '0;
      stop_q   <= 1'b0;
      seen_q   <= 1'b0;
      ovf_q    <= 1'b0;
      total_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      accum_q  <= accum_d;
      remain_q <= remain_d;
      chars_q  <= chars_d;
      stop_q   <= stop_d;
      seen_q   <= seen_d;
      ovf_q    <= ovf_d;
      total_q  <= total_d;
    end
  end

endmodule

@@ design/http_chunked_body_decoder_unit.sv @@
// Top level of the chunked body decoder: input register, framing logic, result register.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  in_item_i  (hcbd_in_t)
//   out      source     out_valid_o/out_stall_i out_item_o (hcbd_out_t)
//
// One word per cycle sustained while the output is not stalled. A word waits in the
// input register until the result register, free or draining, takes its result.
// Reset clears the phase, counters and both valid flags.
// A stalled output holds the result; the input register keeps taking words
// until it is full and the result register cannot drain.
`timescale 1ns / 1ps

module http_chunked_body_decoder_unit import hcbd_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 31,
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hcbd_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output hcbd_out_t out_item_o
);

  logic      in_vld_q, in_vld_d;
  hcbd_in_t  in_item_q;
  logic      out_vld_q, out_vld_d;
  hcbd_out_t out_item_q;
  hcbd_out_t res;
  logic      advance;

  // Move a word into the result register when it is free or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_vld_d   = in_stall_o ? 1'b1 : in_valid_i;
  assign out_vld_d  = advance || (out_vld_q && out_stall_i);

  hcbd_frame #(
    .MAX_DIGITS(MAX_DIGITS),
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_frame (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(in_item_q),
    .res_o (res)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

@@ design/hcbd_checker.sv @@
// Port-level assertions for the chunked body decoder and their bind.
`timescale 1ns / 1ps

module hcbd_checker import hcbd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input hcbd_in_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input hcbd_out_t out_item_o
);

  // Hold a stalled input word
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input word changed");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Non-payload words carry no byte and no chunk end
  a_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.payload_valid |->
      out_item_o.payload_byte == '0 && !out_item_o.chunk_end)
    else $error("framing word carries payload fields");

  // Done never coincides with payload
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.body_done |-> !out_item_o.payload_valid)
    else $error("payload after body done");

  // An edge under reset leaves both channels idle
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("channel active after reset");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (.*);

@@ test/http_chunked_body_decoder_unit_test.sv @@
// Testbench for the chunked body decoder: framed and noisy byte streams checked against a predictor.
`timescale 1ns / 1ps

module http_chunked_body_decoder_unit_test import hcbd_pkg::*;;

  localparam int unsigned MaxDigits  = 31;
  localparam int unsigned SizeW      = 32;
  localparam int unsigned WordTarget = 1050;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;

  // Track decoder state and hold the expected result words in order
  class decode_scoreboard;
    hcbd_phase_e      phase;
    logic [SizeW-1:0] size_accum;
    logic [SizeW-1:0] chunk_size;
    logic [SizeW-1:0] bytes_in_chunk;
    int unsigned      chars_on_line;
    bit               hex_stopped;
    bit               digit_seen;
    bit               overflow_seen;
    logic [31:0]      payload_total;
    hcbd_out_t        expected_q[$];
    int unsigned      live_words;
    int unsigned      ignored_words;
    int unsigned      checked;
    int unsigned      failures;
    int unsigned      payload_seen;
    int unsigned      chunk_ends;
    int unsigned      overflow_results;

    function new();
      clear();
      live_words = 0;
      ignored_words = 0;
      checked = 0;
      failures = 0;
      payload_seen = 0;
      chunk_ends = 0;
      overflow_results = 0;
    endfunction

    function void clear();
      phase = PhSize;
      size_accum = '0;
      chunk_size = '0;
      bytes_in_chunk = '0;
      chars_on_line = 0;
      hex_stopped = 0;
      digit_seen = 0;
      overflow_seen = 0;
      payload_total = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Value of a hex character, or -1 for anything else
    function int nibble_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
      return -1;
    endfunction

    // Accumulate one character of a size line
    function void take_size_char(logic [7:0] c);
      int d;
      logic [SizeW-1:0] size_max;
      size_max = '1;
      if (chars_on_line >= MaxDigits) return;
      chars_on_line++;
      if (hex_stopped) return;
      d = nibble_of(c);
      if (d < 0) begin
        if (!digit_seen && (c == ChrSp || c == ChrTab || c == ChrVt || c == ChrFf)) return;
        hex_stopped = 1;
        return;
      end
      digit_seen = 1;
      if (size_accum > (size_max >> 4)) begin
        size_accum = size_max;
        overflow_seen = 1;
      end else begin
        size_accum = {size_accum[SizeW-5:0], 4'(d)};
      end
    endfunction

    // Advance the prediction by one accepted input word
    function void note_word(hcbd_in_t w);
      hcbd_out_t r;
      logic [7:0] c;
      c = w.body_byte;
      r = '0;
      if (w.restart) clear();
      if (phase == PhDone) ignored_words++;
      else live_words++;
      case (phase)
        PhSize: begin
          if (c == ChrLf) begin
            chunk_size = size_accum;
            size_accum = '0;
            chars_on_line = 0;
            hex_stopped = 0;
            digit_seen = 0;
            bytes_in_chunk = '0;
            phase = (chunk_size == '0) ? PhDone : PhData;
          end else if (c != ChrCr) begin
            take_size_char(c);
          end
        end
        PhData: begin
          r.payload_valid = 1'b1;
          r.payload_byte = c;
          bytes_in_chunk++;
          if (payload_total != '1) payload_total++;
          if (bytes_in_chunk >= chunk_size) begin
            r.chunk_end = 1'b1;
            phase = PhTail;
          end
        end
        PhTail: begin
          if (c == ChrLf) phase = PhSize;
        end
        default: ;
      endcase
      r.body_done = (phase == PhDone);
      r.size_overflow = overflow_seen;
      r.total_payload = payload_total;
      expected_q.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(hcbd_out_t got);
      hcbd_out_t exp_r;
      bit bad;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("unexpected result word: pv=%0d pb=%02h ce=%0d done=%0d ovf=%0d tot=%0d",
                   got.payload_valid, got.payload_byte, got.chunk_end, got.body_done,
                   got.size_overflow, got.total_payload);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      bad = 0;
      if (got.payload_valid !== exp_r.payload_valid) bad = 1;
      if (got.payload_byte !== exp_r.payload_byte) bad = 1;
      if (got.chunk_end !== exp_r.chunk_end) bad = 1;
      if (got.body_done !== exp_r.body_done) bad = 1;
      if (got.size_overflow !== exp_r.size_overflow) bad = 1;
      if (got.total_payload !== exp_r.total_payload) bad = 1;
      if (exp_r.payload_valid) payload_seen++;
      if (exp_r.chunk_end) chunk_ends++;
      if (exp_r.size_overflow) overflow_results++;
      if (bad) begin
        failures++;
        if (failures <= MaxReports)
          $display("mismatch at result %0d: exp pv=%0d pb=%02h ce=%0d done=%0d ovf=%0d tot=%0d",
                   checked, exp_r.payload_valid, exp_r.payload_byte, exp_r.chunk_end,
                   exp_r.body_done, exp_r.size_overflow, exp_r.total_payload);
        if (failures <= MaxReports)
          $display("                          got pv=%0d pb=%02h ce=%0d done=%0d ovf=%0d tot=%0d",
                   got.payload_valid, got.payload_byte, got.chunk_end, got.body_done,
                   got.size_overflow, got.total_payload);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  hcbd_in_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  hcbd_out_t out_item_o;

  decode_scoreboard sb = new();
  hcbd_in_t    word_q[$];
  bit          steady = 0;
  int unsigned cycles = 0;

  http_chunked_body_decoder_unit #(
    .MAX_DIGITS(MaxDigits),
    .SIZE_WIDTH(SizeW)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Take result words and stall the output at random
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
      out_stall_i <= !steady && ($urandom_range(99) < 37);
    end
  end

  task automatic put(input logic [7:0] b, input logic r = 1'b0);
    hcbd_in_t w;
    w.body_byte = b;
    w.restart = r;
    word_q.push_back(w);
  endtask

  // Hold each word until accepted; idle between words at random
  task automatic send_word(input hcbd_in_t w);
    while (!steady && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
  endtask

  task automatic send_queue();
    while (word_q.size() > 0) send_word(word_q.pop_front());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input int unsigned d);
    if (d < 10) return 8'h30 + 8'(d);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0: return ChrSp;
      1: return ChrTab;
      2: return ChrVt;
      default: return ChrFf;
    endcase
  endfunction

  task automatic put_line_end();
    if ($urandom_range(99) < 85) put(ChrCr);
    put(ChrLf);
  endtask

  // Emit a size line for a nonzero size, with optional blanks, zeros and extension
  task automatic put_size_line(input int unsigned size, input logic r);
    int unsigned nib[$];
    int unsigned v;
    logic first_r;
    first_r = r;
    v = size;
    while (v != 0) begin
      nib.push_front(v & 4'hF);
      v = v >> 4;
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        put(blank_char(), first_r);
        first_r = 1'b0;
      end
    end
    if ($urandom_range(4) == 0) begin
      put("0", first_r);
      first_r = 1'b0;
    end
    foreach (nib[i]) begin
      put(hex_char(nib[i]), first_r);
      first_r = 1'b0;
    end
    if ($urandom_range(3) == 0) begin
      put(($urandom_range(1) ? ";" : ChrSp));
      repeat ($urandom_range(0, 6)) put(8'($urandom_range(33, 126)));
    end
    put_line_end();
  endtask

  task automatic put_chunk_data(input int unsigned size);
    repeat (size) put(8'($urandom_range(255)));
    case ($urandom_range(9))
      0: put(ChrLf);
      1: begin
        repeat ($urandom_range(1, 3)) put(8'($urandom_range(11, 255)));
        put(ChrLf);
      end
      default: begin
        put(ChrCr);
        put(ChrLf);
      end
    endcase
  endtask

  // End a body with some line that reads as size zero, then trailing bytes
  task automatic put_last_line();
    case ($urandom_range(4))
      0: put("0");
      1: ;
      2: begin
        put("0");
        put("x");
        put("1");
        put("f");
      end
      3: begin
        put(($urandom_range(1) ? "-" : "+"));
        put("7");
      end
      default: begin
        put("0");
        put("0");
        put(";");
        put("e");
      end
    endcase
    put_line_end();
    repeat ($urandom_range(0, 2)) put(8'($urandom_range(255)));
  endtask

  // Build one body of random shape into the word queue
  task automatic make_body();
    int unsigned kind;
    int unsigned size;
    int unsigned zeros;
    kind = $urandom_range(99);
    if (kind < 70) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(9) < 8) size = $urandom_range(1, 8);
        else size = $urandom_range(9, 64);
        put_size_line(size, word_q.size() == 0);
        put_chunk_data(size);
      end
      put_last_line();
    end else if (kind < 80) begin
      // overlong size line: leading zeros can push the digit past the counted span
      zeros = $urandom_range(26, 34);
      put("0", 1'b1);
      repeat (zeros - 1) put("0");
      size = $urandom_range(1, 9);
      put(hex_char(size));
      repeat ($urandom_range(0, 3)) put(hex_char($urandom_range(15)));
      put_line_end();
      if (zeros + 1 <= MaxDigits) begin
        put_chunk_data((zeros + 1 == MaxDigits) ? size : 0);
        put_last_line();
      end
    end else if (kind < 88) begin
      // size too wide: saturate, pass a few bytes, then restart
      put(hex_char($urandom_range(1, 15)), 1'b1);
      repeat ($urandom_range(8, 11)) put(hex_char($urandom_range(15)));
      put_line_end();
      repeat ($urandom_range(1, 5)) put(8'($urandom_range(255)));
    end else begin
      put(8'($urandom_range(255)), 1'b1);
      repeat ($urandom_range(5, 30)) begin
        case ($urandom_range(3))
          0: put(ChrLf, $urandom_range(9) == 0);
          1: put(ChrCr);
          2: put(hex_char($urandom_range(15)));
          default: put(8'($urandom_range(255)), $urandom_range(9) == 0);
        endcase
      end
    end
  endtask

  initial begin
    int unsigned bodies;
    bodies = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: blanks, extension, payload extremes, tail junk, overflow, 0x prefix, done
    put(ChrSp, 1'b1);
    put(ChrTab);
    put(ChrVt);
    put(ChrFf);
    put("2");
    put(";");
    put(ChrCr);
    put(ChrLf);
    put(8'h00);
    put(8'hFF);
    put("Z");
    put(ChrLf);
    put("1");
    put("2");
    put("3");
    put("4");
    put("5");
    put("6");
    put("7");
    put("8");
    put("9");
    put(ChrLf);
    put("a");
    put("0", 1'b1);
    put("x");
    put("5");
    put(ChrLf);
    put(8'h80);
    send_queue();
    drain();

    // Random bodies; one stretch runs with no idling on either side
    while (sb.live_words < WordTarget) begin
      steady = (sb.live_words >= 400 && sb.live_words < 600);
      make_body();
      send_queue();
      bodies++;
      if (bodies % 8 == 0) drain();
    end
    steady = 0;
    drain();
    repeat (8) @(posedge clk_i);

    $display("covered %0d framed words, %0d ignored words, %0d bodies, %0d results checked",
             sb.live_words, sb.ignored_words, bodies, sb.checked);
    $display("seen %0d payload bytes, %0d chunk ends, %0d results with overflow set",
             sb.payload_seen, sb.chunk_ends, sb.overflow_results);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
